### hw/rtl/cpd_pkg.sv
// ---------------------------------------------------------------------------
// cpd_pkg
// shared types, constants and the crc-32 byte update for the packet deframer
// ---------------------------------------------------------------------------
package cpd_pkg;

    localparam int unsigned MAX_PAYLOAD = 512;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       out_kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [1:0]  pkt_type;
        logic        truncated;
        logic [4:0]  window;
        logic [14:0] data_len;
        logic [7:0]  seqnum;
        logic [31:0] timestamp;
    } t_result;

    function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hw/rtl/cpd_parser.sv
// ---------------------------------------------------------------------------
// cpd_parser
// per-beat header capture, crc update and end-of-packet status decision
// ---------------------------------------------------------------------------
module cpd_parser
    import cpd_pkg::*;
#(
    parameter int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eop,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [15:0] r_pos,    n_pos,    u_pos;
    logic [1:0]  r_type,   n_type,   u_type;
    logic        r_trunc,  n_trunc,  u_trunc;
    logic [4:0]  r_window, n_window, u_window;
    logic [14:0] r_len,    n_len,    u_len;
    logic [7:0]  r_seq,    n_seq,    u_seq;
    logic [31:0] r_ts,     n_ts,     u_ts;
    logic [31:0] r_crc,    n_crc,    u_crc;
    logic [31:0] r_rx,     n_rx,     u_rx;
    logic        r_long,   n_long,   u_long;
    logic [1:0]  r_err,    n_err,    u_err;

    logic [7:0]  crc_byte;
    logic [31:0] crc_next;
    logic [31:0] rx_shift;
    logic [15:0] hb;
    logic [15:0] q;
    logic [15:0] pay_off;
    logic [16:0] len_ext;
    logic [16:0] hsize;
    logic [16:0] cnt;
    logic        have_payload;
    t_status     status;

    assign crc_byte = (r_pos == 16'd0) ? (i_byte & 8'hDF) : i_byte;
    assign crc_next = crc_feed(r_crc, crc_byte);
    assign rx_shift = {r_rx[23:0], i_byte};
    assign hb       = 16'd2 + {15'd0, r_long};
    assign q        = r_pos - hb;
    assign pay_off  = q - 16'd9;
    assign len_ext  = {2'b00, r_len};

    // field capture and crc
    always_comb begin
        u_type       = r_type;
        u_trunc      = r_trunc;
        u_window     = r_window;
        u_len        = r_len;
        u_seq        = r_seq;
        u_ts         = r_ts;
        u_crc        = r_crc;
        u_rx         = r_rx;
        u_long       = r_long;
        u_err        = r_err;
        have_payload = 1'b0;
        if (r_pos == 16'd0) begin
            u_type   = i_byte[7:6];
            u_trunc  = i_byte[5];
            u_window = i_byte[4:0];
            u_len    = '0;
            u_seq    = '0;
            u_ts     = '0;
            u_crc    = crc_next;
        end else if (r_pos == 16'd1) begin
            if (i_byte[7]) begin
                u_long      = 1'b1;
                u_len[14:8] = r_len[14:8] | i_byte[6:0];
            end else begin
                u_len = r_len | {7'd0, i_byte};
            end
            u_crc = crc_next;
        end else if (r_long && r_pos == 16'd2) begin
            u_len = r_len | {7'd0, i_byte};
            u_crc = crc_next;
        end else if (q == 16'd0) begin
            u_seq = r_seq | i_byte;
            u_crc = crc_next;
        end else if (q <= 16'd4) begin
            u_ts  = r_ts | ({24'd0, i_byte} << {q[1:0] - 2'd1, 3'b000});
            u_crc = crc_next;
        end else if (q <= 16'd8) begin
            u_rx = rx_shift;
            if (q == 16'd8) begin
                if (~r_crc != rx_shift) begin
                    u_err[0] = 1'b1;
                end
                u_crc = CRC_INIT;
                u_rx  = '0;
            end
        end else if (!r_trunc) begin
            if ({1'b0, pay_off} < len_ext) begin
                u_crc = crc_next;
                if (!r_err[0] && len_ext <= 17'(PAYLOAD_LIMIT)) begin
                    have_payload = 1'b1;
                end
            end else if ({1'b0, pay_off} < len_ext + 17'd4) begin
                u_rx = rx_shift;
                if ({1'b0, pay_off} == len_ext + 17'd3 && ~r_crc != rx_shift) begin
                    u_err[1] = 1'b1;
                end
            end
        end
        u_pos = (r_pos != 16'hFFFF) ? r_pos + 16'd1 : r_pos;
    end

    // end-of-packet status
    always_comb begin
        cnt   = {1'b0, u_pos};
        hsize = 17'd11 + {16'd0, u_long};
        if (cnt < hsize) begin
            status = ST_LEN_ERR;
        end else if (u_err[0]) begin
            status = ST_CRC_ERR;
        end else if (u_trunc) begin
            status = (cnt != hsize) ? ST_LEN_ERR : ST_OK;
        end else if ({2'b00, u_len} > 17'(PAYLOAD_LIMIT)) begin
            status = ST_TOO_LONG;
        end else if (cnt < hsize + {2'b00, u_len} + 17'd4) begin
            status = ST_LEN_ERR;
        end else if (u_err[1]) begin
            status = ST_CRC_ERR;
        end else if (cnt != hsize + {2'b00, u_len} + 17'd4) begin
            status = ST_LEN_ERR;
        end else begin
            status = ST_OK;
        end
    end

    // result
    always_comb begin
        o_res_valid        = i_eop | have_payload;
        o_res.out_kind     = i_eop ? KIND_SUMMARY : KIND_PAYLOAD;
        o_res.payload_byte = i_eop ? 8'd0 : i_byte;
        o_res.status       = i_eop ? status : ST_OK;
        o_res.pkt_type     = u_type;
        o_res.truncated    = u_trunc;
        o_res.window       = u_window;
        o_res.data_len     = u_len;
        o_res.seqnum       = u_seq;
        o_res.timestamp    = u_ts;
    end

    // packet state returns to reset after the summary
    always_comb begin
        if (i_eop) begin
            n_pos    = '0;
            n_type   = '0;
            n_trunc  = 1'b0;
            n_window = '0;
            n_len    = '0;
            n_seq    = '0;
            n_ts     = '0;
            n_crc    = CRC_INIT;
            n_rx     = '0;
            n_long   = 1'b0;
            n_err    = '0;
        end else begin
            n_pos    = u_pos;
            n_type   = u_type;
            n_trunc  = u_trunc;
            n_window = u_window;
            n_len    = u_len;
            n_seq    = u_seq;
            n_ts     = u_ts;
            n_crc    = u_crc;
            n_rx     = u_rx;
            n_long   = u_long;
            n_err    = u_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_type   <= '0;
            r_trunc  <= 1'b0;
            r_window <= '0;
            r_len    <= '0;
            r_seq    <= '0;
            r_ts     <= '0;
            r_crc    <= CRC_INIT;
            r_rx     <= '0;
            r_long   <= 1'b0;
            r_err    <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_trunc  <= n_trunc;
            r_window <= n_window;
            r_len    <= n_len;
            r_seq    <= n_seq;
            r_ts     <= n_ts;
            r_crc    <= n_crc;
            r_rx     <= n_rx;
            r_long   <= n_long;
            r_err    <= n_err;
        end
    end

endmodule

### hw/rtl/cpd_out_stage.sv
// ---------------------------------------------------------------------------
// cpd_out_stage
// result register between the parser and the output channel
// ---------------------------------------------------------------------------
module cpd_out_stage
    import cpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign n_valid    = i_load || (r_valid && !i_ready);
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### hw/rtl/crc_checked_packet_deframer_core.sv
// ---------------------------------------------------------------------------
// crc_checked_packet_deframer_core
// byte-wide packet deframer with header and payload crc-32 checks
// ---------------------------------------------------------------------------
// The block takes one packet byte per beat and can accept a beat in every
// cycle while not stalled; the single-byte crc-32 update and field capture
// in the parser are combinational, and any result of a beat appears in the
// output register on the next cycle. Payload bytes of an untruncated packet
// come out as payload results while the header crc is good and the length
// is within limits; the beat flagged as end of packet gives only a summary
// result with the status and header fields. Input stalls only while a
// result waits in the output register and the output side is not ready.
module crc_checked_packet_deframer_core
    import cpd_pkg::*;
#(
    parameter int unsigned PAYLOAD_LIMIT = MAX_PAYLOAD
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_status,
    output logic [1:0]  o_pkt_type,
    output logic        o_truncated,
    output logic [4:0]  o_window,
    output logic [14:0] o_data_len,
    output logic [7:0]  o_seqnum,
    output logic [31:0] o_timestamp
);

    logic    accept;
    logic    can_load;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    cpd_parser #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .i_eop       (i_end_of_packet),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cpd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_out_kind     = out_res.out_kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_status       = out_res.status;
    assign o_pkt_type     = out_res.pkt_type;
    assign o_truncated    = out_res.truncated;
    assign o_window       = out_res.window;
    assign o_data_len     = out_res.data_len;
    assign o_seqnum       = out_res.seqnum;
    assign o_timestamp    = out_res.timestamp;

endmodule
